@@ hw/rtl/qtg_pkg.sv @@
// Shared types, constants and saturating helpers of the quintic trajectory generator.
// Used by qtg_cell and quintic_trajectory_generator; depends on nothing else.
package qtg_pkg;

  // default geometry of the time and coefficient formats
  localparam int TIME_WIDTH_DEF = 32;
  localparam int TIME_FRAC_DEF  = 24;
  localparam int COEF_FRAC_DEF  = 48;

  localparam int COEF_W    = 64;
  localparam int OUT_W     = 48;
  localparam int OUT_FRAC  = 32;
  localparam int NUM_COEF  = 6;
  localparam int NUM_CELLS = 5;
  localparam int NUM_LANES = 3;
  localparam int CFG_IDX_W = 4;

  // lanes of the evaluator: position, velocity, acceleration
  localparam int LANE_POS = 0;
  localparam int LANE_VEL = 1;
  localparam int LANE_ACC = 2;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // register reset values
  localparam logic [63:0] FINISH_RST = 64'd167772160;
  localparam coef_t COEF_RST [NUM_COEF] = '{
    64'sd0, 64'sd0, 64'sd0, -64'sd1797710000000, 64'sd138472000000, -64'sd291521000
  };

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_RUN    = 2'd1,
    PH_DONE   = 2'd2
  } qtg_phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TIME  = 4'd0,
    REG_FINISH_TIME = 4'd1,
    REG_COEF_0      = 4'd2,
    REG_COEF_1      = 4'd3,
    REG_COEF_2      = 4'd4,
    REG_COEF_3      = 4'd5,
    REG_COEF_4      = 4'd6,
    REG_COEF_5      = 4'd7
  } qtg_reg_e;

  // control that travels along the cell chain with each sample
  typedef struct packed {
    logic       valid;
    qtg_phase_e phase;
  } qtg_ctrl_t;

  // value with its clip flag
  typedef struct packed {
    logic  ovf;
    coef_t val;
  } qtg_sat_t;

  // saturating 64-bit add
  function automatic qtg_sat_t sat_add(coef_t a, coef_t b);
    logic signed [COEF_W:0] s;
    qtg_sat_t r;
    s = $signed({a[COEF_W-1], a}) + $signed({b[COEF_W-1], b});
    r.ovf = s[COEF_W] ^ s[COEF_W-1];
    r.val = r.ovf ? (s[COEF_W] ? COEF_MIN : COEF_MAX) : coef_t'(s[COEF_W-1:0]);
    return r;
  endfunction

  // saturating scale by a small constant
  function automatic qtg_sat_t sat_scale(coef_t c, logic [4:0] k);
    logic signed [COEF_W+5:0] p;
    qtg_sat_t r;
    p = $signed({{6{c[COEF_W-1]}}, c}) * $signed({{(COEF_W+1){1'b0}}, k});
    r.ovf = !((&p[COEF_W+5:COEF_W-1]) || !(|p[COEF_W+5:COEF_W-1]));
    r.val = r.ovf ? (p[COEF_W+5] ? COEF_MIN : COEF_MAX) : coef_t'(p[COEF_W-1:0]);
    return r;
  endfunction

endpackage

@@ hw/rtl/qtg_cell.sv @@
// One Horner step for the position, velocity and acceleration lanes, two stages deep.
// Depends on qtg_pkg.
module qtg_cell import qtg_pkg::*; #(
  parameter int TIME_WIDTH     = TIME_WIDTH_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  qtg_ctrl_t              ctrl_i,
  input  logic [TIME_WIDTH-1:0]  d_i,
  input  coef_t                  acc_i  [NUM_LANES],
  input  logic [NUM_LANES-1:0]   sat_i,
  input  coef_t                  coef_i [NUM_LANES],
  output qtg_ctrl_t              ctrl_o,
  output logic [TIME_WIDTH-1:0]  d_o,
  output coef_t                  acc_o  [NUM_LANES],
  output logic [NUM_LANES-1:0]   sat_o
);

  localparam int PhW = 33 + TIME_WIDTH;
  localparam int PlW = 32 + TIME_WIDTH;
  localparam int PW  = 65 + TIME_WIDTH;

  // stage a: partial products
  qtg_ctrl_t                   ctrl_a_q;
  logic [TIME_WIDTH-1:0]       d_a_q;
  logic [NUM_LANES-1:0]        sat_a_q;
  logic signed [PhW-1:0]       pph_d [NUM_LANES];
  logic signed [PhW-1:0]       pph_q [NUM_LANES];
  logic [PlW-1:0]              ppl_d [NUM_LANES];
  logic [PlW-1:0]              ppl_q [NUM_LANES];

  // stage b: recombine, truncate, clip, add coefficient
  qtg_ctrl_t                   ctrl_q;
  logic [TIME_WIDTH-1:0]       d_q;
  coef_t                       acc_d [NUM_LANES];
  coef_t                       acc_q [NUM_LANES];
  logic                        sat_d [NUM_LANES];
  logic [NUM_LANES-1:0]        sat_q;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic signed [PW-1:0] prod_full;
    logic signed [PW-1:0] prod_shr;
    logic                 prod_ovf;
    coef_t                prod_sat;
    qtg_sat_t             sum;

    // signed upper half and unsigned lower half of the accumulator times d
    assign pph_d[l] = $signed({{(TIME_WIDTH+1){acc_i[l][COEF_W-1]}}, acc_i[l][COEF_W-1:32]})
                    * $signed({33'b0, d_i});
    assign ppl_d[l] = {{TIME_WIDTH{1'b0}}, acc_i[l][31:0]} * {32'b0, d_i};

    // full product, floor shift back to the coefficient format
    assign prod_full = ($signed({{32{pph_q[l][PhW-1]}}, pph_q[l]}) <<< 32)
                     + $signed({33'b0, ppl_q[l]});
    assign prod_shr  = prod_full >>> TIME_FRAC_BITS;
    assign prod_ovf  = !((&prod_shr[PW-1:COEF_W-1]) || !(|prod_shr[PW-1:COEF_W-1]));
    assign prod_sat  = prod_ovf ? (prod_shr[PW-1] ? COEF_MIN : COEF_MAX)
                                : coef_t'(prod_shr[COEF_W-1:0]);

    assign sum      = sat_add(prod_sat, coef_i[l]);
    assign acc_d[l] = sum.val;
    assign sat_d[l] = sat_a_q[l] | prod_ovf | sum.ovf;
  end

  // control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
      ctrl_q   <= '0;
    end else begin
      ctrl_a_q <= ctrl_i;
      ctrl_q   <= ctrl_a_q;
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    d_a_q   <= d_i;
    sat_a_q <= sat_i;
    d_q     <= d_a_q;
    for (int l = 0; l < NUM_LANES; l++) begin
      pph_q[l] <= pph_d[l];
      ppl_q[l] <= ppl_d[l];
      acc_q[l] <= acc_d[l];
      sat_q[l] <= sat_d[l];
    end
  end

  assign ctrl_o = ctrl_q;
  assign d_o    = d_q;
  assign acc_o  = acc_q;
  assign sat_o  = sat_q;

endmodule

@@ hw/rtl/quintic_trajectory_generator.sv @@
// Top level of the quintic trajectory generator: configuration registers, phase
// decode, a row of qtg_cell Horner steps and output scaling. Depends on qtg_pkg, qtg_cell.
//
// Usage
//   A sample time is taken on current_time_i at every clock edge where start is high
//   and busy is low. busy is always low: the evaluator is fully pipelined and takes
//   one sample per cycle, back to back.
//   Each result appears on position_o, velocity_o, acceleration_o, phase_o and
//   saturated_o for exactly one cycle while done_o is high. The pipeline has
//   one phase decode stage, five Horner cells of two stages each (a split 64 x time
//   multiply, then recombine, clip and add), and one output scaling stage. Results
//   leave in the order the samples came in; the receiver cannot stall, so nothing
//   is ever held back.
//   Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i;
//   indexes above 7 are ignored. Writes are meant for an empty pipeline.
//   Reset clears the pipeline valid bits and loads the default profile: start 0 s,
//   finish 10 s and the default polynomial coefficients.
module quintic_trajectory_generator import qtg_pkg::*; #(
  parameter int TIME_WIDTH     = TIME_WIDTH_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [TIME_WIDTH-1:0]  current_time_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [COEF_W-1:0]      cfg_wdata_i,
  output logic                   done_o,
  output logic signed [OUT_W-1:0] position_o,
  output logic signed [OUT_W-1:0] velocity_o,
  output logic signed [OUT_W-1:0] acceleration_o,
  output logic [1:0]             phase_o,
  output logic                   saturated_o
);

  localparam int ShL     = (COEF_FRAC_BITS < OUT_FRAC) ? OUT_FRAC - COEF_FRAC_BITS : 0;
  localparam int ShR     = (COEF_FRAC_BITS >= OUT_FRAC) ? COEF_FRAC_BITS - OUT_FRAC : 0;
  localparam int Latency = 2 * NUM_CELLS + 2;

  localparam logic signed [OUT_W-1:0] OutMax = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OutMin = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic                   ovf;
    logic [OUT_W-1:0]       val;
  } out_sat_t;

  // coefficient format to output format, floor shift and clip
  function automatic out_sat_t to_out(coef_t v);
    logic signed [COEF_W+7:0] w;
    out_sat_t r;
    w = ($signed({{8{v[COEF_W-1]}}, v}) <<< ShL) >>> ShR;
    r.ovf = !((&w[COEF_W+7:OUT_W-1]) || !(|w[COEF_W+7:OUT_W-1]));
    r.val = r.ovf ? (w[COEF_W+7] ? OutMin : OutMax) : w[OUT_W-1:0];
    return r;
  endfunction

  // configuration registers
  logic [TIME_WIDTH-1:0] start_q;
  logic [TIME_WIDTH-1:0] finish_q;
  coef_t                 coef_q [NUM_COEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      finish_q <= TIME_WIDTH'(FINISH_RST);
      for (int k = 0; k < NUM_COEF; k++) begin
        coef_q[k] <= COEF_RST[k];
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_START_TIME) begin
        start_q <= cfg_wdata_i[TIME_WIDTH-1:0];
      end
      if (cfg_idx_i == REG_FINISH_TIME) begin
        finish_q <= cfg_wdata_i[TIME_WIDTH-1:0];
      end
      for (int k = 0; k < NUM_COEF; k++) begin
        if (cfg_idx_i == CFG_IDX_W'(int'(REG_COEF_0) + k)) begin
          coef_q[k] <= coef_t'(cfg_wdata_i);
        end
      end
    end
  end

  // every sample is taken on transfer
  assign busy = 1'b0;

  // phase decode and time offset
  logic                  before_start;
  logic                  after_finish;
  logic [TIME_WIDTH-1:0] span;
  logic [TIME_WIDTH-1:0] d_d;
  qtg_ctrl_t             front_ctrl_d;
  qtg_ctrl_t             front_ctrl_q;
  logic [TIME_WIDTH-1:0] front_d_q;

  assign before_start = current_time_i < start_q;
  assign after_finish = current_time_i >= finish_q;
  assign span         = (finish_q >= start_q) ? finish_q - start_q : '0;

  always_comb begin
    front_ctrl_d.valid = start && !busy;
    if (before_start) begin
      front_ctrl_d.phase = PH_BEFORE;
      d_d                = '0;
    end else if (after_finish) begin
      front_ctrl_d.phase = PH_DONE;
      d_d                = span;
    end else begin
      front_ctrl_d.phase = PH_RUN;
      d_d                = current_time_i - start_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_ctrl_q <= '0;
    end else begin
      front_ctrl_q <= front_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_d_q <= d_d;
  end

  // derivative coefficients, clipped
  qtg_sat_t vs5, vs4, vs3, vs2, as5, as4, as3;
  logic     deriv_ovf;

  assign vs5       = sat_scale(coef_q[5], 5'd5);
  assign vs4       = sat_scale(coef_q[4], 5'd4);
  assign vs3       = sat_scale(coef_q[3], 5'd3);
  assign vs2       = sat_scale(coef_q[2], 5'd2);
  assign as5       = sat_scale(coef_q[5], 5'd20);
  assign as4       = sat_scale(coef_q[4], 5'd12);
  assign as3       = sat_scale(coef_q[3], 5'd6);
  assign deriv_ovf = vs5.ovf | vs4.ovf | vs3.ovf | vs2.ovf | as5.ovf | as4.ovf | as3.ovf;

  // per-cell coefficients; velocity and acceleration start from zero so all lanes
  // run through the same five steps
  coef_t cell_coef [NUM_CELLS][NUM_LANES];

  always_comb begin
    cell_coef[0][LANE_POS] = coef_q[4];
    cell_coef[1][LANE_POS] = coef_q[3];
    cell_coef[2][LANE_POS] = coef_q[2];
    cell_coef[3][LANE_POS] = coef_q[1];
    cell_coef[4][LANE_POS] = coef_q[0];
    cell_coef[0][LANE_VEL] = vs5.val;
    cell_coef[1][LANE_VEL] = vs4.val;
    cell_coef[2][LANE_VEL] = vs3.val;
    cell_coef[3][LANE_VEL] = vs2.val;
    cell_coef[4][LANE_VEL] = coef_q[1];
    cell_coef[0][LANE_ACC] = '0;
    cell_coef[1][LANE_ACC] = as5.val;
    cell_coef[2][LANE_ACC] = as4.val;
    cell_coef[3][LANE_ACC] = as3.val;
    cell_coef[4][LANE_ACC] = vs2.val;
  end

  // chain of cells
  qtg_ctrl_t             ctrl_l [NUM_CELLS+1];
  logic [TIME_WIDTH-1:0] d_l    [NUM_CELLS+1];
  coef_t                 acc_l  [NUM_CELLS+1][NUM_LANES];
  logic [NUM_LANES-1:0]  sat_l  [NUM_CELLS+1];

  assign ctrl_l[0]           = front_ctrl_q;
  assign d_l[0]              = front_d_q;
  assign acc_l[0][LANE_POS]  = coef_q[5];
  assign acc_l[0][LANE_VEL]  = '0;
  assign acc_l[0][LANE_ACC]  = '0;
  assign sat_l[0]            = '0;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    qtg_cell #(
      .TIME_WIDTH     (TIME_WIDTH),
      .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_l[g]),
      .d_i    (d_l[g]),
      .acc_i  (acc_l[g]),
      .sat_i  (sat_l[g]),
      .coef_i (cell_coef[g]),
      .ctrl_o (ctrl_l[g+1]),
      .d_o    (d_l[g+1]),
      .acc_o  (acc_l[g+1]),
      .sat_o  (sat_l[g+1])
    );
  end

  // output scaling and phase select
  qtg_ctrl_t            last_ctrl;
  logic [NUM_LANES-1:0] last_sat;
  out_sat_t             coef0_out;
  out_sat_t             pos_out;
  out_sat_t             vel_out;
  out_sat_t             acc_out;
  logic                 run;
  logic                 sat_d;
  logic [OUT_W-1:0]     pos_d;
  logic [OUT_W-1:0]     vel_d;
  logic [OUT_W-1:0]     acc_d;

  assign last_ctrl = ctrl_l[NUM_CELLS];
  assign last_sat  = sat_l[NUM_CELLS];
  assign coef0_out = to_out(coef_q[0]);
  assign pos_out   = to_out(acc_l[NUM_CELLS][LANE_POS]);
  assign vel_out   = to_out(acc_l[NUM_CELLS][LANE_VEL]);
  assign acc_out   = to_out(acc_l[NUM_CELLS][LANE_ACC]);
  assign run       = last_ctrl.phase == PH_RUN;

  always_comb begin
    if (last_ctrl.phase == PH_BEFORE) begin
      pos_d = coef0_out.val;
      sat_d = coef0_out.ovf;
    end else begin
      pos_d = pos_out.val;
      sat_d = pos_out.ovf | last_sat[LANE_POS];
    end
    if (run) begin
      vel_d = vel_out.val;
      acc_d = acc_out.val;
      sat_d = sat_d | vel_out.ovf | acc_out.ovf | last_sat[LANE_VEL] | last_sat[LANE_ACC]
            | deriv_ovf;
    end else begin
      vel_d = '0;
      acc_d = '0;
    end
  end

  // result registers
  logic             done_q;
  logic [OUT_W-1:0] pos_q;
  logic [OUT_W-1:0] vel_q;
  logic [OUT_W-1:0] acc_q;
  qtg_phase_e       phase_q;
  logic             sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last_ctrl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    vel_q   <= vel_d;
    acc_q   <= acc_d;
    phase_q <= last_ctrl.phase;
    sat_q   <= sat_d;
  end

  assign done_o         = done_q;
  assign position_o     = $signed(pos_q);
  assign velocity_o     = $signed(vel_q);
  assign acceleration_o = $signed(acc_q);
  assign phase_o        = phase_q;
  assign saturated_o    = sat_q;

  // every result comes from a matching earlier input transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without matching input transfer");

  // outside the window the derivatives are zero
  a_zero_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && phase_o != PH_RUN) |-> (velocity_o == '0 && acceleration_o == '0))
    else $error("nonzero derivative outside the window");

  // before the start the position is the constant coefficient
  a_before_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && phase_o == PH_BEFORE) |->
      (position_o == $signed(coef0_out.val) && saturated_o == coef0_out.ovf))
    else $error("position before start does not match coefficient zero");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench of quintic_trajectory_generator: streams sample times and register
// writes, predicts position, velocity, acceleration, phase and clip flag for every sample.
// Depends on qtg_pkg and the RTL of quintic_trajectory_generator.
module tb import qtg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 181;

  localparam logic signed [127:0] WIDE_MAX = 128'sh7fff_ffff_ffff_ffff;
  localparam logic signed [127:0] WIDE_MIN = -WIDE_MAX - 1;
  localparam logic signed [127:0] OUT_MAX  = (128'sd1 <<< (OUT_W - 1)) - 1;
  localparam logic signed [127:0] OUT_MIN  = -OUT_MAX - 1;

  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_vec_t;

  typedef enum logic [1:0] {
    ACT_SAMPLE,
    ACT_WRITE,
    ACT_DRAIN,
    ACT_PACE
  } act_e;

  typedef struct {
    act_e                 kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          data;
  } plan_t;

  typedef struct {
    logic signed [OUT_W-1:0] pos;
    logic signed [OUT_W-1:0] vel;
    logic signed [OUT_W-1:0] acc;
    qtg_phase_e              phase;
    logic                    sat;
  } point_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   start          = 1'b0;
  logic                   busy;
  logic [31:0]            current_time_i = '0;
  logic                   cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i      = '0;
  logic [COEF_W-1:0]      cfg_wdata_i    = '0;
  logic                   done_o;
  logic signed [OUT_W-1:0] position_o;
  logic signed [OUT_W-1:0] velocity_o;
  logic signed [OUT_W-1:0] acceleration_o;
  logic [1:0]             phase_o;
  logic                   saturated_o;

  // register image seen by the predictor
  logic [31:0] prof_start  = '0;
  logic [31:0] prof_finish = FINISH_RST[31:0];
  coef_vec_t   prof_coef;

  // window known while the stimulus is planned
  logic [31:0] plan_start  = '0;
  logic [31:0] plan_finish = FINISH_RST[31:0];

  plan_t  plan_q[$];
  point_t expected_q[$];
  int     pace_pct    = 0;
  int     errors      = 0;
  int     cycle_count = 0;

  quintic_trajectory_generator DUT (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .current_time_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .done_o,
    .position_o,
    .velocity_o,
    .acceleration_o,
    .phase_o,
    .saturated_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // clip a wide value into the 64-bit accumulator
  function automatic qtg_sat_t clip64(logic signed [127:0] v);
    qtg_sat_t r;
    r.ovf = (v > WIDE_MAX) || (v < WIDE_MIN);
    r.val = (v > WIDE_MAX) ? COEF_MAX : (v < WIDE_MIN) ? COEF_MIN : v[63:0];
    return r;
  endfunction

  // accumulator times elapsed time, floored back to Q16.48
  function automatic qtg_sat_t mul_time(coef_t a, logic [31:0] t);
    logic signed [127:0] aw;
    logic signed [127:0] tw;
    aw = a;
    tw = {96'd0, t};
    return clip64((aw * tw) >>> TIME_FRAC_DEF);
  endfunction

  function automatic qtg_sat_t add_clip(coef_t a, coef_t b);
    logic signed [127:0] aw;
    logic signed [127:0] bw;
    aw = a;
    bw = b;
    return clip64(aw + bw);
  endfunction

  function automatic qtg_sat_t scale_clip(coef_t c, int k);
    logic signed [127:0] cw;
    cw = c;
    return clip64(cw * k);
  endfunction

  // horner evaluation, highest order first
  function automatic qtg_sat_t eval_poly(coef_vec_t c, int n, logic [31:0] d);
    qtg_sat_t acc;
    qtg_sat_t m;
    qtg_sat_t s;
    acc.ovf = 1'b0;
    acc.val = c[0];
    for (int i = 1; i < n; i++) begin
      m = mul_time(acc.val, d);
      s = add_clip(m.val, c[i]);
      acc.val = s.val;
      acc.ovf = acc.ovf | m.ovf | s.ovf;
    end
    return acc;
  endfunction

  // Q16.48 down to Q16.32 with floor, clipped to the port width
  function automatic qtg_sat_t to_q32(coef_t v);
    logic signed [127:0] r;
    qtg_sat_t o;
    r = v;
    r = r >>> (COEF_FRAC_DEF - OUT_FRAC);
    o.ovf = (r > OUT_MAX) || (r < OUT_MIN);
    r = (r > OUT_MAX) ? OUT_MAX : (r < OUT_MIN) ? OUT_MIN : r;
    o.val = r[63:0];
    return o;
  endfunction

  // expected profile point for one sample time
  function automatic point_t trajectory_at(logic [31:0] t);
    coef_vec_t pc;
    coef_vec_t vc;
    coef_vec_t ac;
    qtg_sat_t  p;
    qtg_sat_t  v;
    qtg_sat_t  a;
    qtg_sat_t  o;
    logic      sat;
    point_t    r;
    sat   = 1'b0;
    p.ovf = 1'b0;
    p.val = prof_coef[0];
    v.ovf = 1'b0;
    v.val = '0;
    a     = v;
    vc    = '0;
    ac    = '0;
    for (int i = 0; i < NUM_COEF; i++) pc[i] = prof_coef[NUM_COEF-1-i];
    if (t < prof_start) begin
      r.phase = PH_BEFORE;
    end else if (t >= prof_finish) begin
      r.phase = PH_DONE;
      p = eval_poly(pc, 6, (prof_finish >= prof_start) ? prof_finish - prof_start : '0);
    end else begin
      r.phase = PH_RUN;
      p = eval_poly(pc, 6, t - prof_start);
      // derivative coefficients: k*c_k and k*(k-1)*c_k
      for (int i = 0; i < 4; i++) begin
        o     = scale_clip(prof_coef[5-i], 5 - i);
        vc[i] = o.val;
        sat   = sat | o.ovf;
        o     = scale_clip(prof_coef[5-i], (5 - i) * (4 - i));
        ac[i] = o.val;
        sat   = sat | o.ovf;
      end
      vc[4] = prof_coef[1];
      v = eval_poly(vc, 5, t - prof_start);
      a = eval_poly(ac, 4, t - prof_start);
    end
    sat = sat | p.ovf | v.ovf | a.ovf;
    o = to_q32(p.val);
    r.pos = o.val[OUT_W-1:0];
    sat = sat | o.ovf;
    o = to_q32(v.val);
    r.vel = o.val[OUT_W-1:0];
    sat = sat | o.ovf;
    o = to_q32(a.val);
    r.acc = o.val[OUT_W-1:0];
    r.sat = sat | o.ovf;
    return r;
  endfunction

  function automatic coef_t rand_coef(int shift);
    coef_t c;
    c = {$urandom, $urandom};
    return c >>> shift;
  endfunction

  // sample time: mostly inside the window, some at its borders, some anywhere
  function automatic logic [31:0] rand_time();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return plan_start + $urandom_range(2) - 1;
      3: return plan_finish + $urandom_range(2) - 1;
      default: begin
        if (plan_finish > plan_start)
          return plan_start + $urandom_range(plan_finish - plan_start - 1);
        return $urandom;
      end
    endcase
  endfunction

  task automatic add_sample(logic [31:0] t);
    plan_q.push_back('{kind: ACT_SAMPLE, idx: '0, data: {32'd0, t}});
  endtask

  task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    plan_q.push_back('{kind: ACT_WRITE, idx: idx, data: data});
    if (idx == REG_START_TIME) plan_start = data[31:0];
    if (idx == REG_FINISH_TIME) plan_finish = data[31:0];
  endtask

  task automatic add_pace(int pct);
    plan_q.push_back('{kind: ACT_PACE, idx: '0, data: 64'(pct)});
  endtask

  task automatic add_drain();
    plan_q.push_back('{kind: ACT_DRAIN, idx: '0, data: '0});
  endtask

  // one full register set of a given flavor
  task automatic plan_profile(int kind);
    logic [31:0] st;
    logic [31:0] fin;
    coef_vec_t   c;
    case (kind)
      0: begin
        st = $urandom_range(32'h7fff_ffff);
        fin = st + $urandom_range(32'h3fff_ffff) + 1;
        for (int i = 0; i < NUM_COEF; i++) c[i] = rand_coef($urandom_range(63, 8));
      end
      1: begin
        st = $urandom;
        fin = $urandom;
        for (int i = 0; i < NUM_COEF; i++) c[i] = rand_coef(0);
      end
      2: begin
        st = $urandom_range(1) ? 32'd0 : 32'($urandom_range(255));
        fin = 32'hffff_ffff;
        for (int i = 0; i < NUM_COEF; i++) begin
          case ($urandom_range(4))
            0: c[i] = COEF_MAX;
            1: c[i] = COEF_MIN;
            2: c[i] = '1;
            3: c[i] = 64'd1;
            default: c[i] = rand_coef(0);
          endcase
        end
      end
      default: begin
        st = $urandom;
        fin = $urandom_range(1) ? st : $urandom_range(st);
        for (int i = 0; i < NUM_COEF; i++) c[i] = rand_coef($urandom_range(40));
      end
    endcase
    add_write(REG_START_TIME, {$urandom, st});
    add_write(REG_FINISH_TIME, {$urandom, fin});
    for (int i = 0; i < NUM_COEF; i++) add_write(CFG_IDX_W'(REG_COEF_0 + i), c[i]);
    if ($urandom_range(1)) add_write(CFG_IDX_W'($urandom_range(15, 8)), {$urandom, $urandom});
  endtask

  // driver: issues samples and register writes from the plan
  always @(posedge clk_i) begin : driver
    logic next_start;
    logic next_we;
    if (rst_ni) begin
      if (start && !busy) expected_q.push_back(trajectory_at(current_time_i));
      next_start = start && busy;
      next_we = 1'b0;
      if (!next_start && plan_q.size() != 0) begin
        case (plan_q[0].kind)
          ACT_SAMPLE: if (!cfg_we_i && $urandom_range(99) >= pace_pct) begin
            next_start = 1'b1;
            current_time_i <= plan_q[0].data[31:0];
            void'(plan_q.pop_front());
          end
          ACT_WRITE: if (!start && expected_q.size() == 0) begin
            next_we = 1'b1;
            cfg_idx_i <= plan_q[0].idx;
            cfg_wdata_i <= plan_q[0].data;
            case (plan_q[0].idx)
              REG_START_TIME: prof_start = plan_q[0].data[31:0];
              REG_FINISH_TIME: prof_finish = plan_q[0].data[31:0];
              REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3, REG_COEF_4, REG_COEF_5:
                prof_coef[plan_q[0].idx - REG_COEF_0] = plan_q[0].data;
              default: ;
            endcase
            void'(plan_q.pop_front());
          end
          ACT_DRAIN: if (!start && expected_q.size() == 0) begin
            void'(plan_q.pop_front());
          end
          default: begin
            pace_pct = int'(plan_q[0].data);
            void'(plan_q.pop_front());
          end
        endcase
      end
      start <= next_start;
      cfg_we_i <= next_we;
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // monitor: every result transfer against the oldest prediction
  always @(posedge clk_i) begin : monitor
    point_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual position %0d", $time,
                 position_o);
      end else begin
        want = expected_q.pop_front();
        check_field("position", want.pos, position_o);
        check_field("velocity", want.vel, velocity_o);
        check_field("acceleration", want.acc, acceleration_o);
        check_field("phase", want.phase, phase_o);
        check_field("saturated", want.sat, saturated_o);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] corner_times [9];
    corner_times = '{
      32'h0000_0000, 32'h0000_0001, 32'h0500_0000, 32'h09ff_ffff, 32'h0a00_0000,
      32'h0a00_0001, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff
    };
    for (int i = 0; i < NUM_COEF; i++) prof_coef[i] = COEF_RST[i];

    // default profile straight out of reset
    add_pace(0);
    foreach (corner_times[i]) add_sample(corner_times[i]);

    // widest window with all coefficients at the positive, then negative limit
    add_write(REG_START_TIME, '0);
    add_write(REG_FINISH_TIME, {$urandom, 32'hffff_ffff});
    for (int i = 0; i < NUM_COEF; i++) add_write(CFG_IDX_W'(REG_COEF_0 + i), COEF_MAX);
    add_sample(32'hffff_fffe);
    add_sample(32'h0000_0001);
    add_sample(32'h0000_0000);
    for (int i = 0; i < NUM_COEF; i++) add_write(CFG_IDX_W'(REG_COEF_0 + i), COEF_MIN);
    add_sample(32'hffff_fffe);
    add_sample(32'h0100_0000);

    // finish below start: zero span, everything from start on is done
    add_write(REG_START_TIME, 64'h4000_0000);
    add_write(REG_FINISH_TIME, 64'h2000_0000);
    add_write(REG_COEF_0, rand_coef(8));
    add_sample(32'h3fff_ffff);
    add_sample(32'h4000_0000);
    add_sample(32'h1000_0000);
    add_sample(32'hffff_ffff);

    // empty window, negative offset that floors on output scaling
    add_write(REG_START_TIME, 64'h0100_0000);
    add_write(REG_FINISH_TIME, 64'h0100_0000);
    add_write(REG_COEF_0, '1);
    add_sample(32'h00ff_ffff);
    add_sample(32'h0100_0000);

    // write to an unused index must change nothing
    add_write(CFG_IDX_W'($urandom_range(15, 8)), '1);
    add_sample(32'h0080_0000);

    // random profiles under different sender pacing
    for (int p = 0; p < PHASES; p++) begin
      case (p % 3)
        0: add_pace(0);
        1: add_pace(70);
        default: add_pace(34);
      endcase
      plan_profile(p % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && p % 2 == 1) add_drain();
        add_sample(rand_time());
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (plan_q.size() != 0 || start || expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
